FILE: design/mpbd_pkg.sv
// Shared widths and reset constants for the max-per-bucket level downsampler.
// No dependencies; imported by every module of the block.
package mpbd_pkg;

    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 8;
    localparam int COLUMN_W = 10;

    localparam int DEFAULT_OUT_COLUMNS = 720;
    localparam logic [COUNT_W-1:0] RESET_SOURCE_COUNT = 16'd720;

endpackage

FILE: design/mpbd_divider.sv
// Two-stage constant divider that splits a source count into the per-bucket
// quotient and remainder by OUT_COLUMNS. Depends on mpbd_pkg.
module mpbd_divider
    import mpbd_pkg::*;
#(
    parameter int OUT_COLUMNS = DEFAULT_OUT_COLUMNS,
    localparam int REM_W = $clog2(OUT_COLUMNS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [COUNT_W-1:0] count,
    output logic [COUNT_W-1:0] step_quotient,
    output logic [REM_W-1:0]   step_remainder
);

    localparam int SHIFT = COUNT_W + $clog2(OUT_COLUMNS);
    localparam int RECIP_W = COUNT_W + 2;
    localparam int PROD_W = COUNT_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(OUT_COLUMNS) - 64'd1) / 64'(OUT_COLUMNS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int RESET_EFF = (RESET_SOURCE_COUNT == '0) ? 1 : int'(RESET_SOURCE_COUNT);
    localparam logic [COUNT_W-1:0] RESET_Q = COUNT_W'(RESET_EFF / OUT_COLUMNS);
    localparam logic [REM_W-1:0] RESET_R = REM_W'(RESET_EFF % OUT_COLUMNS);

    logic [COUNT_W-1:0] eff_count;
    logic [PROD_W-1:0]  product;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] quot_reg;
    logic               stage_valid_reg;
    logic [COUNT_W-1:0] quot_times_cols;
    logic [COUNT_W-1:0] step_quotient_reg;
    logic [REM_W-1:0]   step_remainder_reg;

    // The reciprocal is rounded up with enough fraction bits to be exact for
    // every 16-bit count.
    assign eff_count = (count == '0) ? COUNT_W'(1) : count;
    assign product = PROD_W'(eff_count) * PROD_W'(RECIP);
    assign quot_times_cols = COUNT_W'(quot_reg * COUNT_W'(OUT_COLUMNS));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_reg <= eff_count;
            quot_reg <= COUNT_W'(product >> SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            step_quotient_reg <= RESET_Q;
            step_remainder_reg <= RESET_R;
        end
        else
        begin
            stage_valid_reg <= load;
            if (stage_valid_reg)
            begin
                step_quotient_reg <= quot_reg;
                step_remainder_reg <= REM_W'(count_reg - quot_times_cols);
            end
        end
    end

    assign step_quotient = step_quotient_reg;
    assign step_remainder = step_remainder_reg;

endmodule

FILE: design/max_per_bucket_level_downsampler.sv
// Max-per-bucket level downsampler, top level.
// Depends on mpbd_pkg and mpbd_divider.
//
// The block takes 8-bit levels and registers each result into a two-entry
// output stage, so the input keeps flowing while a result waits. A write to
// source_count restarts the record and holds in_ready low while the setup
// counter runs down and the divider pipeline produces the new bucket step;
// otherwise one item is accepted every cycle while the skid entry is empty.
module max_per_bucket_level_downsampler
    import mpbd_pkg::*;
#(
    parameter int OUT_COLUMNS = DEFAULT_OUT_COLUMNS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [LEVEL_W-1:0]  sample_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEVEL_W-1:0]  level,
    output logic [COLUMN_W-1:0] column,
    output logic                last
);

    localparam int REM_W = $clog2(OUT_COLUMNS + 1);
    localparam int WIDE_W = (REM_W > COLUMN_W) ? REM_W : COLUMN_W;
    localparam int RESET_EFF = (RESET_SOURCE_COUNT == '0) ? 1 : int'(RESET_SOURCE_COUNT);
    localparam logic [COUNT_W-1:0] RESET_Q = COUNT_W'(RESET_EFF / OUT_COLUMNS);
    localparam logic [REM_W-1:0] RESET_R = REM_W'(RESET_EFF % OUT_COLUMNS);
    localparam logic [1:0] SETUP_CYCLES = 2'd2;

    logic [COUNT_W-1:0] source_count_reg;
    logic [COUNT_W-1:0] sample_index_reg;
    logic [REM_W-1:0]   column_index_reg;
    logic [LEVEL_W-1:0] running_max_reg;
    logic [COUNT_W-1:0] bucket_end_reg;
    logic [REM_W-1:0]   bucket_remainder_reg;
    logic [1:0]         setup_cnt_reg;

    logic [COUNT_W-1:0] step_quotient;
    logic [REM_W-1:0]   step_remainder;

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [COLUMN_W-1:0] out_column_reg;
    logic               out_last_reg;
    logic               skid_valid_reg;
    logic [LEVEL_W-1:0] skid_level_reg;
    logic [COLUMN_W-1:0] skid_column_reg;
    logic               skid_last_reg;

    logic [COUNT_W-1:0] eff_count;
    logic               pass_mode;
    logic               accept;
    logic [COUNT_W-1:0] idx_inc;
    logic               is_last;
    logic               bucket_done;
    logic [LEVEL_W-1:0] max_val;
    logic               produce;
    logic [LEVEL_W-1:0] res_level;
    logic [COLUMN_W-1:0] res_column;
    logic [WIDE_W-1:0]  column_wide;
    logic [REM_W:0]     rem_sum;
    logic               rem_wrap;
    logic [REM_W-1:0]   bucket_remainder_next;
    logic [COUNT_W-1:0] bucket_end_next;
    logic               push;
    logic               taken;
    logic               out_load;
    logic               skid_load;

    mpbd_divider #(
        .OUT_COLUMNS (OUT_COLUMNS)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (cfg_write),
        .count          (cfg_data),
        .step_quotient  (step_quotient),
        .step_remainder (step_remainder)
    );

    assign eff_count = (source_count_reg == '0) ? COUNT_W'(1) : source_count_reg;
    assign pass_mode = (eff_count <= COUNT_W'(OUT_COLUMNS));
    assign in_ready = (setup_cnt_reg == '0) && !skid_valid_reg;
    assign accept = in_valid && in_ready;

    assign idx_inc = sample_index_reg + COUNT_W'(1);
    assign is_last = (idx_inc == eff_count);
    assign bucket_done = (idx_inc == bucket_end_reg);
    assign max_val = (sample_level > running_max_reg) ? sample_level : running_max_reg;
    assign produce = pass_mode || bucket_done;

    assign column_wide = WIDE_W'(column_index_reg);
    assign res_level = pass_mode ? sample_level : max_val;
    assign res_column = pass_mode ? sample_index_reg[COLUMN_W-1:0]
                                  : column_wide[COLUMN_W-1:0];

    assign rem_sum = {1'b0, bucket_remainder_reg} + {1'b0, step_remainder};
    assign rem_wrap = (rem_sum >= (REM_W + 1)'(OUT_COLUMNS));
    assign bucket_remainder_next = rem_wrap ? REM_W'(rem_sum - (REM_W + 1)'(OUT_COLUMNS))
                                            : REM_W'(rem_sum);
    assign bucket_end_next = bucket_end_reg + step_quotient + COUNT_W'(rem_wrap);

    assign push = accept && produce;
    assign taken = out_valid_reg && out_ready;
    assign out_load = push && (!out_valid_reg || taken);
    assign skid_load = push && out_valid_reg && !taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= RESET_SOURCE_COUNT;
            sample_index_reg <= '0;
            column_index_reg <= '0;
            running_max_reg <= '0;
            bucket_end_reg <= RESET_Q;
            bucket_remainder_reg <= RESET_R;
            setup_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= skid_valid_reg || push || (out_valid_reg && !taken);
            skid_valid_reg <= skid_load || (skid_valid_reg && !taken);

            if (cfg_write)
            begin
                source_count_reg <= cfg_data;
                sample_index_reg <= '0;
                column_index_reg <= '0;
                running_max_reg <= '0;
                setup_cnt_reg <= SETUP_CYCLES;
            end
            else if (setup_cnt_reg != '0)
            begin
                setup_cnt_reg <= setup_cnt_reg - 2'd1;
                if (setup_cnt_reg == 2'd1)
                begin
                    bucket_end_reg <= step_quotient;
                    bucket_remainder_reg <= step_remainder;
                end
            end
            else if (accept)
            begin
                if (is_last && produce)
                begin
                    sample_index_reg <= '0;
                    column_index_reg <= '0;
                    running_max_reg <= '0;
                    bucket_end_reg <= step_quotient;
                    bucket_remainder_reg <= step_remainder;
                end
                else if (pass_mode)
                begin
                    sample_index_reg <= idx_inc;
                end
                else if (bucket_done)
                begin
                    sample_index_reg <= idx_inc;
                    running_max_reg <= '0;
                    column_index_reg <= column_index_reg + REM_W'(1);
                    bucket_end_reg <= bucket_end_next;
                    bucket_remainder_reg <= bucket_remainder_next;
                end
                else
                begin
                    sample_index_reg <= idx_inc;
                    running_max_reg <= max_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg <= res_level;
            out_column_reg <= res_column;
            out_last_reg <= is_last;
        end
        else if (skid_valid_reg && taken)
        begin
            out_level_reg <= skid_level_reg;
            out_column_reg <= skid_column_reg;
            out_last_reg <= skid_last_reg;
        end
        if (skid_load)
        begin
            skid_level_reg <= res_level;
            skid_column_reg <= res_column;
            skid_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign level = out_level_reg;
    assign column = out_column_reg;
    assign last = out_last_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (sample_index_reg == '0) && (column_index_reg == '0)
                      && (running_max_reg == '0))
        else $error("Record state not cleared after a source count write.");

    assert property (@(posedge clk) disable iff (!rst_n)
        bucket_remainder_reg < REM_W'(OUT_COLUMNS))
        else $error("Bucket remainder reached the column count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (setup_cnt_reg == '0) && !pass_mode |-> sample_index_reg < bucket_end_reg)
        else $error("Sample index passed the current bucket end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && pass_mode |=> out_valid_reg)
        else $error("Pass-through item produced no result.");
`endif

endmodule

FILE: test/tb_max_per_bucket_level_downsampler.sv
// Testbench for the max-per-bucket level downsampler: random and directed records
// are checked against a bucket-maximum predictor held in a small scoreboard class.
// Depends on mpbd_pkg and the max_per_bucket_level_downsampler RTL.
module tb_max_per_bucket_level_downsampler;
    timeunit 1ns;
    timeprecision 1ps;
    import mpbd_pkg::*;

    localparam int OUT_COLUMNS = DEFAULT_OUT_COLUMNS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BACKLOG_CYCLES = 300;
    localparam int IDLE_PCT = 8;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [COLUMN_W-1:0] column;
        logic                last;
    } column_item_t;

    class bucket_scoreboard;
        logic [COUNT_W-1:0] source_count;
        int unsigned        sample_idx;
        int unsigned        column_idx;
        int unsigned        bucket_stop;
        int unsigned        bucket_frac;
        logic [LEVEL_W-1:0] peak;
        column_item_t       expected_columns[$];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
            source_count = RESET_SOURCE_COUNT;
            restart();
        endfunction

        function int unsigned samples_per_record();
            return (source_count == 0) ? 1 : int'(source_count);
        endfunction

        function void restart();
            int unsigned n;
            n = samples_per_record();
            sample_idx = 0;
            column_idx = 0;
            peak = '0;
            bucket_stop = n / OUT_COLUMNS;
            bucket_frac = n % OUT_COLUMNS;
        endfunction

        function void write_count(logic [COUNT_W-1:0] value);
            source_count = value;
            restart();
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        function void note_sample(logic [LEVEL_W-1:0] value);
            int unsigned        n;
            logic [LEVEL_W-1:0] top;
            column_item_t       item;
            bit                 at_end;
            n = samples_per_record();
            at_end = (sample_idx + 1 == n);
            if (n <= OUT_COLUMNS) begin
                item.level = value;
                item.column = COLUMN_W'(sample_idx);
                item.last = at_end;
                expected_columns.push_back(item);
                if (at_end)
                    restart();
                else
                    sample_idx++;
                return;
            end
            top = (value > peak) ? value : peak;
            if (sample_idx + 1 == bucket_stop) begin
                item.level = top;
                item.column = COLUMN_W'(column_idx);
                item.last = at_end;
                expected_columns.push_back(item);
                if (at_end) begin
                    restart();
                end
                else begin
                    peak = '0;
                    column_idx++;
                    bucket_stop += n / OUT_COLUMNS;
                    bucket_frac += n % OUT_COLUMNS;
                    if (bucket_frac >= OUT_COLUMNS) begin
                        bucket_frac -= OUT_COLUMNS;
                        bucket_stop++;
                    end
                    sample_idx++;
                end
            end
            else begin
                peak = top;
                sample_idx++;
            end
        endfunction

        function void check_column(logic [LEVEL_W-1:0] got_level,
                                   logic [COLUMN_W-1:0] got_column, logic got_last);
            column_item_t want;
            if (expected_columns.size() == 0) begin
                $error("unexpected item: level %0d column %0d last %0d",
                       got_level, got_column, got_last);
                mismatches++;
                return;
            end
            want = expected_columns.pop_front();
            if (got_level !== want.level) begin
                $error("level: expected %0d, actual %0d", want.level, got_level);
                mismatches++;
            end
            if (got_column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got_column);
                mismatches++;
            end
            if (got_last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [COUNT_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [LEVEL_W-1:0]  sample_level = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [LEVEL_W-1:0]  level;
    logic [COLUMN_W-1:0] column;
    logic                last;

    bit steady = 1'b0;
    bit backlog_req = 1'b0;
    bit backlog_done = 1'b0;

    bucket_scoreboard sb = new();

    max_per_bucket_level_downsampler #(
        .OUT_COLUMNS(OUT_COLUMNS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_level(sample_level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .level(level),
        .column(column),
        .last(last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic send_sample(logic [LEVEL_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_level <= value;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(value);
    endtask

    task automatic load_source_count(logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_count(value);
    endtask

    task automatic send_record_part(logic [COUNT_W-1:0] count, int unsigned items);
        load_source_count(count);
        repeat (items) send_sample(LEVEL_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_column(level, column, last);
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end
            else if (backlog_req && !backlog_done) begin
                backlog_done = 1'b1;
                hold = BACKLOG_CYCLES;
                out_ready <= 1'b0;
            end
            else if (steady) begin
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned items;
        int unsigned kind;
        logic [COUNT_W-1:0] count;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset count passes samples straight through.
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hA5);
        // A count of zero acts as one; the write also restarts a partial record.
        load_source_count(16'd0);
        send_sample(8'hFF);
        send_sample(8'h00);
        load_source_count(16'd1);
        send_sample(8'h5A);
        load_source_count(16'd3);
        send_sample(8'h01);
        send_sample(8'h80);
        send_sample(8'h7F);
        send_sample(8'hFE);
        // Two-sample buckets with a carry every record.
        load_source_count(16'd1441);
        send_sample(8'd10);
        send_sample(8'd200);
        send_sample(8'd7);
        send_sample(8'd3);
        send_sample(8'd255);
        send_sample(8'd0);
        // Widest count, abandoned before its first bucket closes.
        load_source_count(16'hFFFF);
        repeat (5) send_sample(LEVEL_W'($urandom_range(0, 255)));

        // One full record just past the column count, with a long output stall.
        load_source_count(16'(OUT_COLUMNS + 1));
        backlog_req = 1'b1;
        items = OUT_COLUMNS + 1 + $urandom_range(0, 20);
        repeat (items) send_sample(LEVEL_W'($urandom_range(0, 255)));
        random_sent = items;

        while (random_sent < RANDOM_ITEMS) begin
            steady = (random_sent >= 800 && random_sent < 1100);
            kind = $urandom_range(0, 15);
            case (kind)
                0: begin
                    count = '0;
                    items = $urandom_range(1, 6);
                end
                1: begin
                    count = 16'hFFFF;
                    items = $urandom_range(1, 200);
                end
                2: begin
                    count = 16'(OUT_COLUMNS - $urandom_range(0, 1));
                    items = $urandom_range(1, 40);
                end
                3, 4: begin
                    count = 16'($urandom_range(OUT_COLUMNS + 1, 3 * OUT_COLUMNS));
                    items = $urandom_range(1, 150);
                end
                default: begin
                    count = 16'($urandom_range(1, 24));
                    items = $urandom_range(1, 3 * count);
                end
            endcase
            send_record_part(count, items);
            random_sent += items;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
design/mpbd_pkg.sv
design/mpbd_divider.sv
design/max_per_bucket_level_downsampler.sv
test/tb_max_per_bucket_level_downsampler.sv
